@@ rtl/core/tshlc_pkg.sv @@
package tshlc_pkg;

   // register map
   localparam int RULE_REGS  = 4;
   localparam int RULE_W     = 54;
   localparam int GRID_W     = 11;
   localparam int MATCH_W    = 2;
   localparam int COUNT_W    = 3;
   localparam int SCALE_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 54;

   localparam logic [CSR_IDX_W-1:0] REG_LAYER0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LAYER1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LAYER2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LAYER3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GRID   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MATCH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE  = 3'd7;

   // rule field layout
   localparam int RULE_HEIGHT_W = 16;
   localparam int SLOPE_W       = 7;
   localparam int PRIO_W        = 8;
   localparam int RULE_MIN_LSB  = 0;
   localparam int RULE_MAX_LSB  = 16;
   localparam int RULE_SLO_LSB  = 32;
   localparam int RULE_SHI_LSB  = 39;
   localparam int RULE_PRI_LSB  = 46;

   localparam logic [SLOPE_W-1:0] SLOPE_RIGHT = 7'd90;
   localparam logic [SLOPE_W-1:0] SLOPE_ZERO  = 7'd0;
   localparam logic [SLOPE_W-1:0] SLOPE_45    = 7'd45;

   localparam logic [MATCH_W-1:0] MATCH_RESET = 2'd3;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
   localparam int MATCH_HEIGHT_BIT = 0;
   localparam int MATCH_SLOPE_BIT  = 1;

   // input modes
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_FLUSH  = 1'b1;

   localparam int LAYER_IDX_W  = 2;
   localparam int TAN_W        = 14;
   localparam int QUEUE_DEPTH  = 8;
   localparam int QUEUE_PTR_W  = 3;
   localparam int QUEUE_CNT_W  = 4;
   localparam int PEND_W       = 3;

   typedef struct packed {
      logic [RULE_REGS-1:0][RULE_W-1:0] rules;
      logic [MATCH_W-1:0]               match_mode;
      logic [COUNT_W-1:0]               layer_count;
      logic [SCALE_W-1:0]               scale;
   } cfg_type;

   typedef struct packed {
      logic [LAYER_IDX_W-1:0] layer_index;
      logic                   painted;
      logic                   frame_end;
   } result_type;

   // floor(256 * tan(d degrees)) for whole degrees below 90
   function automatic logic [TAN_W-1:0] tan_q8(input logic [SLOPE_W-1:0] d);
      logic [TAN_W-1:0] t;
      unique case (d)
         7'd0: t = 14'd0;     7'd1: t = 14'd4;     7'd2: t = 14'd8;
         7'd3: t = 14'd13;    7'd4: t = 14'd17;    7'd5: t = 14'd22;
         7'd6: t = 14'd26;    7'd7: t = 14'd31;    7'd8: t = 14'd35;
         7'd9: t = 14'd40;    7'd10: t = 14'd45;   7'd11: t = 14'd49;
         7'd12: t = 14'd54;   7'd13: t = 14'd59;   7'd14: t = 14'd63;
         7'd15: t = 14'd68;   7'd16: t = 14'd73;   7'd17: t = 14'd78;
         7'd18: t = 14'd83;   7'd19: t = 14'd88;   7'd20: t = 14'd93;
         7'd21: t = 14'd98;   7'd22: t = 14'd103;  7'd23: t = 14'd108;
         7'd24: t = 14'd113;  7'd25: t = 14'd119;  7'd26: t = 14'd124;
         7'd27: t = 14'd130;  7'd28: t = 14'd136;  7'd29: t = 14'd141;
         7'd30: t = 14'd147;  7'd31: t = 14'd153;  7'd32: t = 14'd159;
         7'd33: t = 14'd166;  7'd34: t = 14'd172;  7'd35: t = 14'd179;
         7'd36: t = 14'd185;  7'd37: t = 14'd192;  7'd38: t = 14'd200;
         7'd39: t = 14'd207;  7'd40: t = 14'd214;  7'd41: t = 14'd222;
         7'd42: t = 14'd230;  7'd43: t = 14'd238;  7'd44: t = 14'd247;
         7'd45: t = 14'd256;  7'd46: t = 14'd265;  7'd47: t = 14'd274;
         7'd48: t = 14'd284;  7'd49: t = 14'd294;  7'd50: t = 14'd305;
         7'd51: t = 14'd316;  7'd52: t = 14'd327;  7'd53: t = 14'd339;
         7'd54: t = 14'd352;  7'd55: t = 14'd365;  7'd56: t = 14'd379;
         7'd57: t = 14'd394;  7'd58: t = 14'd409;  7'd59: t = 14'd426;
         7'd60: t = 14'd443;  7'd61: t = 14'd461;  7'd62: t = 14'd481;
         7'd63: t = 14'd502;  7'd64: t = 14'd524;  7'd65: t = 14'd548;
         7'd66: t = 14'd574;  7'd67: t = 14'd603;  7'd68: t = 14'd633;
         7'd69: t = 14'd666;  7'd70: t = 14'd703;  7'd71: t = 14'd743;
         7'd72: t = 14'd787;  7'd73: t = 14'd837;  7'd74: t = 14'd892;
         7'd75: t = 14'd955;  7'd76: t = 14'd1026; 7'd77: t = 14'd1108;
         7'd78: t = 14'd1204; 7'd79: t = 14'd1317; 7'd80: t = 14'd1451;
         7'd81: t = 14'd1616; 7'd82: t = 14'd1821; 7'd83: t = 14'd2084;
         7'd84: t = 14'd2435; 7'd85: t = 14'd2926; 7'd86: t = 14'd3660;
         7'd87: t = 14'd4884; 7'd88: t = 14'd7330; 7'd89: t = 14'd14666;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

@@ rtl/core/tshlc_front.sv @@
module tshlc_front
   import tshlc_pkg::*;
#(
   parameter int MAX_GRID    = 1024,
   parameter int LAYERS      = 4,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cfg_type                               cfg,
   input  logic [$clog2(MAX_GRID+1)-1:0]         grid_n,
   input  logic [2*$clog2(MAX_GRID+1)-1:0]       grid_total,
   input  logic                                  restart,
   input  logic                                  in_valid,
   input  logic                                  in_mode,
   input  logic [HEIGHT_BITS-1:0]                in_height,
   output logic                                  out_valid,
   output result_type                            out_result,
   output logic [PEND_W-1:0]                     pend_count
);

   localparam int NW = $clog2(MAX_GRID+1);
   localparam int TW = 2*NW;
   localparam int AW = $clog2(MAX_GRID);
   localparam int HB = HEIGHT_BITS;
   localparam int PW = HB + SCALE_W;
   localparam int CW = ((HB > RULE_HEIGHT_W) ? HB : RULE_HEIGHT_W) + 1;
   localparam int NUM_RULES = (LAYERS < RULE_REGS) ? LAYERS : RULE_REGS;

   // frame position counters
   logic [TW-1:0] recv_ff, recv_in, emit_ff, emit_in;
   logic [NW-1:0] er_ff, er_in, ec_ff, ec_in, pc_ff, pc_in;

   logic full, real_push, flush_emit, sample_emit, emit, push, last_emit;
   logic [TW:0] recv_next_w, need_w;

   always_comb begin
      full        = recv_ff >= grid_total;
      real_push   = in_valid && (in_mode == MODE_SAMPLE) && !full;
      flush_emit  = in_valid && full && (emit_ff < grid_total);
      recv_next_w = {1'b0, recv_ff} + (TW+1)'(1);
      need_w      = {1'b0, emit_ff} + (TW+1)'(grid_n) + (TW+1)'(2);
      sample_emit = real_push && (emit_ff < grid_total) && (recv_next_w >= need_w);
      emit        = sample_emit || flush_emit;
      push        = real_push || flush_emit;
      last_emit   = ({1'b0, emit_ff} + (TW+1)'(1)) >= {1'b0, grid_total};
   end

   // advance counters, wrap at frame end
   always_comb begin
      recv_in = recv_ff;
      emit_in = emit_ff;
      er_in   = er_ff;
      ec_in   = ec_ff;
      pc_in   = pc_ff;
      if (real_push) begin
         recv_in = recv_ff + TW'(1);
      end
      if (push) begin
         pc_in = (pc_ff == grid_n - NW'(1)) ? '0 : pc_ff + NW'(1);
      end
      if (emit) begin
         emit_in = emit_ff + TW'(1);
         if (ec_ff == grid_n - NW'(1)) begin
            ec_in = '0;
            er_in = er_ff + NW'(1);
         end else begin
            ec_in = ec_ff + NW'(1);
         end
         if (last_emit) begin
            recv_in = '0;
            emit_in = '0;
            er_in   = '0;
            ec_in   = '0;
            pc_in   = '0;
         end
      end
      if (restart) begin
         recv_in = '0;
         emit_in = '0;
         er_in   = '0;
         ec_in   = '0;
         pc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recv_ff <= '0;
         emit_ff <= '0;
         er_ff   <= '0;
         ec_ff   <= '0;
         pc_ff   <= '0;
      end else begin
         recv_ff <= recv_in;
         emit_ff <= emit_in;
         er_ff   <= er_in;
         ec_ff   <= ec_in;
         pc_ff   <= pc_in;
      end
   end

   // stage A: capture transaction, read line buffers
   logic          a_push_ff, a_emit_ff, a_real_ff;
   logic [HB-1:0] a_x_ff;
   logic [AW-1:0] a_pc_ff;
   logic [3:0]    a_edge_ff;   // top, bottom, left, right neighbours present
   logic          a_last_ff, a_single_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_push_ff <= 1'b0;
         a_emit_ff <= 1'b0;
      end else begin
         a_push_ff <= push;
         a_emit_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      a_real_ff   <= real_push;
      a_x_ff      <= in_height;
      a_pc_ff     <= pc_ff[AW-1:0];
      a_edge_ff   <= {er_ff != '0, er_ff != grid_n - NW'(1),
                      ec_ff != '0, ec_ff != grid_n - NW'(1)};
      a_last_ff   <= emit_ff == grid_total - TW'(1);
      a_single_ff <= grid_n == NW'(1);
   end

   logic [HB-1:0] older_mem [MAX_GRID];
   logic [HB-1:0] newer_mem [MAX_GRID];
   logic [HB-1:0] rd_old_ff, rd_new_ff;

   // line buffers: newer row feeds older row
   always_ff @(posedge clock) begin
      if (push) begin
         rd_new_ff <= newer_mem[pc_ff[AW-1:0]];
      end
      if (a_push_ff) begin
         newer_mem[a_pc_ff] <= a_x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rd_old_ff <= older_mem[pc_ff[AW-1:0]];
      end
      if (a_push_ff) begin
         older_mem[a_pc_ff] <= rd_new_ff;
      end
   end

   // stage B: shift 3x3 window
   logic [2:0][2:0][HB-1:0] win_ff;   // [row][col], row 0 oldest
   logic [HB-1:0]           last_real_ff;
   logic                    b_emit_ff, b_last_ff, b_single_ff;
   logic [3:0]              b_edge_ff;

   always_ff @(posedge clock) begin
      if (a_push_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= rd_old_ff;
         win_ff[1][2] <= rd_new_ff;
         win_ff[2][2] <= a_x_ff;
         if (a_real_ff) begin
            last_real_ff <= a_x_ff;
         end
      end
      b_last_ff   <= a_last_ff;
      b_single_ff <= a_single_ff;
      b_edge_ff   <= a_edge_ff;
   end

   // stage C: largest absolute difference to present neighbours
   logic [HB-1:0] center, maxd;
   logic          c_emit_ff, c_last_ff, d_emit_ff, d_last_ff;
   logic [HB-1:0] c_maxd_ff, c_h_ff, d_h_ff;
   logic [PW-1:0] d_prod_ff;

   always_comb begin
      logic          present;
      logic [HB:0]   diff;
      logic [HB-1:0] mag;
      center = b_single_ff ? last_real_ff : win_ff[1][1];
      maxd   = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            present = !(r == 1 && c == 1)
                      && (r != 0 || b_edge_ff[3]) && (r != 2 || b_edge_ff[2])
                      && (c != 0 || b_edge_ff[1]) && (c != 2 || b_edge_ff[0]);
            diff = (HB+1)'(signed'(win_ff[r][c])) - (HB+1)'(signed'(center));
            mag  = diff[HB] ? HB'(-diff) : diff[HB-1:0];
            if (present && mag > maxd) begin
               maxd = mag;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_emit_ff <= 1'b0;
         c_emit_ff <= 1'b0;
         d_emit_ff <= 1'b0;
      end else begin
         b_emit_ff <= a_emit_ff;
         c_emit_ff <= b_emit_ff;
         d_emit_ff <= c_emit_ff;
      end
   end

   // stage D: scale the rise
   always_ff @(posedge clock) begin
      c_maxd_ff <= maxd;
      c_h_ff    <= center;
      c_last_ff <= b_last_ff;
      d_prod_ff <= PW'(c_maxd_ff) * PW'(cfg.scale);
      d_h_ff    <= c_h_ff;
      d_last_ff <= c_last_ff;
   end

   // stage E: match rules, highest priority wins, ties to higher index
   logic [COUNT_W-1:0]     cnt_eff;
   logic                   found;
   logic [LAYER_IDX_W-1:0] best_idx;
   logic [PRIO_W-1:0]      best_pri;

   always_comb begin
      logic [RULE_W-1:0]  w;
      logic signed [CW-1:0] h_ext, mn_ext, mx_ext;
      logic [SLOPE_W-1:0] slo, shi;
      logic [PRIO_W-1:0]  pr;
      logic [PW-1:0]      t_lo, t_hi;
      logic               ok;
      cnt_eff  = (cfg.layer_count > COUNT_W'(NUM_RULES)) ? COUNT_W'(NUM_RULES)
                                                         : cfg.layer_count;
      found    = 1'b0;
      best_idx = '0;
      best_pri = '0;
      h_ext    = CW'(signed'(d_h_ff));
      for (int i = 0; i < NUM_RULES; i++) begin
         w      = cfg.rules[i];
         mn_ext = CW'(signed'(w[RULE_MIN_LSB +: RULE_HEIGHT_W]));
         mx_ext = CW'(signed'(w[RULE_MAX_LSB +: RULE_HEIGHT_W]));
         slo    = w[RULE_SLO_LSB +: SLOPE_W];
         shi    = w[RULE_SHI_LSB +: SLOPE_W];
         pr     = w[RULE_PRI_LSB +: PRIO_W];
         t_lo   = PW'(tan_q8(slo));
         t_hi   = PW'(tan_q8(shi));
         ok     = COUNT_W'(i) < cnt_eff;
         if (cfg.match_mode[MATCH_HEIGHT_BIT] && (h_ext < mn_ext || h_ext > mx_ext)) begin
            ok = 1'b0;
         end
         if (cfg.match_mode[MATCH_SLOPE_BIT]) begin
            if (slo >= SLOPE_RIGHT || d_prod_ff < t_lo) begin
               ok = 1'b0;
            end
            if (d_prod_ff == t_lo && slo != SLOPE_ZERO && slo != SLOPE_45) begin
               ok = 1'b0;
            end
            if (shi < SLOPE_RIGHT && d_prod_ff > t_hi) begin
               ok = 1'b0;
            end
         end
         if (ok && (!found || pr >= best_pri)) begin
            found    = 1'b1;
            best_idx = LAYER_IDX_W'(i);
            best_pri = pr;
         end
      end
   end

   assign out_valid              = d_emit_ff;
   assign out_result.layer_index = best_idx;
   assign out_result.painted     = found;
   assign out_result.frame_end   = d_last_ff;

   assign pend_count = PEND_W'(a_emit_ff) + PEND_W'(b_emit_ff)
                     + PEND_W'(c_emit_ff) + PEND_W'(d_emit_ff);

endmodule

@@ rtl/core/tshlc_queue.sv @@
module tshlc_queue
   import tshlc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_valid,
   input  result_type             wr_data,
   output logic                   rd_valid,
   output result_type             rd_data,
   input  logic                   rd_take,
   output logic [QUEUE_CNT_W-1:0] count
);

   result_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wp_ff, rp_ff;
   logic [QUEUE_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                       pop;

   assign rd_valid = cnt_ff != '0;
   assign rd_data  = slot_ff[rp_ff];
   assign pop      = rd_valid && rd_take;
   assign count    = cnt_ff;

   always_comb begin
      cnt_in = cnt_ff + QUEUE_CNT_W'(wr_valid) - QUEUE_CNT_W'(pop);
   end

   // hold results until the consumer takes them
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (wr_valid) begin
            wp_ff <= wp_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rp_ff <= rp_ff + QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         slot_ff[wp_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/core/terrain_slope_height_layer_classifier_core.sv @@
// Channel | Dir | Ports                                  | Handshake
// req     | in  | req_mode, req_height                   | req_valid / req_stall
// rsp     | out | rsp_layer_index, rsp_painted,          | rsp_valid / rsp_stall
//         |     | rsp_frame_end                          |
// csr     | in  | csr_index, csr_data                    | csr_valid / csr_ready
//
// One transaction per cycle while req_stall is low; a released result passes through
// line buffer read, window shift, difference, scale and rule match into the result queue.
// Results lag samples by one row plus one cell; flush transactions drain the rest.
// Reset clears counters and the result queue; line buffers are not cleared.
// req_stall rises when the eight-entry result queue plus results in flight is full.
module terrain_slope_height_layer_classifier_core
   import tshlc_pkg::*;
#(
   parameter int MAX_GRID    = 1024,
   parameter int LAYERS      = 4,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic [HEIGHT_BITS-1:0] req_height,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [LAYER_IDX_W-1:0] rsp_layer_index,
   output logic                   rsp_painted,
   output logic                   rsp_frame_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int NW = $clog2(MAX_GRID+1);
   localparam int TW = 2*NW;

   cfg_type       cfg_ff, cfg_in;
   logic [NW-1:0] grid_n_ff, grid_n_in;
   logic [TW-1:0] total_ff, total_in;
   logic          csr_wr, restart;
   logic [GRID_W-1:0] grid_val;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign restart   = csr_wr && (csr_index == REG_GRID);
   assign grid_val  = csr_data[GRID_W-1:0];

   // decode register writes; clamp the side length
   always_comb begin
      cfg_in    = cfg_ff;
      grid_n_in = grid_n_ff;
      if (grid_val == '0) begin
         grid_n_in = NW'(1);
      end else if (32'(grid_val) > 32'(MAX_GRID)) begin
         grid_n_in = NW'(MAX_GRID);
      end else begin
         grid_n_in = NW'(grid_val);
      end
      if (!restart) begin
         grid_n_in = grid_n_ff;
      end
      total_in = TW'(grid_n_in) * TW'(grid_n_in);
      if (csr_wr) begin
         unique case (csr_index)
            REG_LAYER0: cfg_in.rules[0]   = csr_data[RULE_W-1:0];
            REG_LAYER1: cfg_in.rules[1]   = csr_data[RULE_W-1:0];
            REG_LAYER2: cfg_in.rules[2]   = csr_data[RULE_W-1:0];
            REG_LAYER3: cfg_in.rules[3]   = csr_data[RULE_W-1:0];
            REG_GRID:   cfg_in            = cfg_ff;
            REG_MATCH:  cfg_in.match_mode = csr_data[MATCH_W-1:0];
            REG_COUNT:  cfg_in.layer_count = csr_data[COUNT_W-1:0];
            REG_SCALE:  cfg_in.scale      = csr_data[SCALE_W-1:0];
            default:    cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rules       <= '0;
         cfg_ff.match_mode  <= MATCH_RESET;
         cfg_ff.layer_count <= '0;
         cfg_ff.scale       <= SCALE_RESET;
         grid_n_ff          <= NW'(1);
         total_ff           <= TW'(1);
      end else begin
         cfg_ff    <= cfg_in;
         grid_n_ff <= grid_n_in;
         total_ff  <= total_in;
      end
   end

   logic                   req_take, front_valid;
   result_type             front_result, queue_data;
   logic [PEND_W-1:0]      front_pend;
   logic [QUEUE_CNT_W-1:0] queue_count;
   logic [QUEUE_CNT_W:0]   pend_total;

   assign req_take   = req_valid && !req_stall;
   assign pend_total = (QUEUE_CNT_W+1)'(queue_count) + (QUEUE_CNT_W+1)'(front_pend);
   assign req_stall  = pend_total >= (QUEUE_CNT_W+1)'(QUEUE_DEPTH);

   tshlc_front #(
      .MAX_GRID    (MAX_GRID),
      .LAYERS      (LAYERS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .grid_n     (grid_n_ff),
      .grid_total (total_ff),
      .restart    (restart),
      .in_valid   (req_take),
      .in_mode    (req_mode),
      .in_height  (req_height),
      .out_valid  (front_valid),
      .out_result (front_result),
      .pend_count (front_pend)
   );

   tshlc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_data  (front_result),
      .rd_valid (rsp_valid),
      .rd_data  (queue_data),
      .rd_take  (!rsp_stall),
      .count    (queue_count)
   );

   assign rsp_layer_index = queue_data.layer_index;
   assign rsp_painted     = queue_data.painted;
   assign rsp_frame_end   = queue_data.frame_end;

`ifndef ASSERT_OFF
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      pend_total <= (QUEUE_CNT_W+1)'(QUEUE_DEPTH))
      else $error("result queue overrun");

   a_unpainted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_painted |-> rsp_layer_index == '0)
      else $error("layer index set without a match");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result presented right after reset");
`endif

endmodule

@@ tb/terrain_slope_height_layer_classifier_core_tb.sv @@
module terrain_slope_height_layer_classifier_core_tb
   import tshlc_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_LIMIT = 1024;

   typedef struct packed {
      logic       mode;
      logic [15:0] height;
   } sample_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_mode = MODE_SAMPLE;
   logic [15:0]            req_height = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [LAYER_IDX_W-1:0] rsp_layer_index;
   logic                   rsp_painted;
   logic                   rsp_frame_end;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   terrain_slope_height_layer_classifier_core i_dut (.*);

   always #4 clock = ~clock;

   // floor(256 * tan(d)) per whole degree
   const int unsigned rise_limit[90] = '{
      0, 4, 8, 13, 17, 22, 26, 31, 35, 40,
      45, 49, 54, 59, 63, 68, 73, 78, 83, 88,
      93, 98, 103, 108, 113, 119, 124, 130, 136, 141,
      147, 153, 159, 166, 172, 179, 185, 192, 200, 207,
      214, 222, 230, 238, 247, 256, 265, 274, 284, 294,
      305, 316, 327, 339, 352, 365, 379, 394, 409, 426,
      443, 461, 481, 502, 524, 548, 574, 603, 633, 666,
      703, 743, 787, 837, 892, 955, 1026, 1108, 1204, 1317,
      1451, 1616, 1821, 2084, 2435, 2926, 3660, 4884, 7330, 14666};

   // shadow configuration and frame state
   logic [RULE_W-1:0]  rule_sh [RULE_REGS];
   int unsigned        grid_sh = 1;
   logic [MATCH_W-1:0] match_sh = MATCH_RESET;
   int unsigned        count_sh = 0;
   int unsigned        scale_sh = SCALE_RESET;
   int unsigned        cells_in = 0;
   int unsigned        cells_out = 0;
   int                 cell_height [int];

   sample_type pending_samples [$];
   result_type expected_labels [$];
   int         mismatches = 0;
   bit         calm = 1'b0;
   bit         hold_ask = 1'b0;

   function automatic int unsigned map_side();
      if (grid_sh == 0) return 1;
      if (grid_sh > GRID_LIMIT) return GRID_LIMIT;
      return grid_sh;
   endfunction

   function automatic bit slope_pass(longint unsigned rise, int unsigned lo, int unsigned hi);
      if (lo >= 90) return 1'b0;
      if (rise < rise_limit[lo]) return 1'b0;
      if (rise == rise_limit[lo] && lo != 0 && lo != 45) return 1'b0;
      if (hi < 90 && rise > rise_limit[hi]) return 1'b0;
      return 1'b1;
   endfunction

   // label one cell from its clipped 3x3 neighbourhood
   function automatic result_type label_cell(int unsigned e, int unsigned n);
      int unsigned     r, c, y0, y1, x0, x1, cnt, pr, bestp;
      int              h, dv, best;
      longint unsigned maxd;
      logic [RULE_W-1:0] w;
      result_type      res;
      r = e / n;
      c = e % n;
      h = cell_height[e];
      maxd = 0;
      y0 = (r != 0) ? r - 1 : 0;
      y1 = (r + 1 < n) ? r + 1 : n - 1;
      x0 = (c != 0) ? c - 1 : 0;
      x1 = (c + 1 < n) ? c + 1 : n - 1;
      for (int unsigned y = y0; y <= y1; y++) begin
         for (int unsigned x = x0; x <= x1; x++) begin
            if (!(y == r && x == c)) begin
               dv = cell_height[y * n + x] - h;
               if (dv < 0) dv = -dv;
               if (dv > maxd) maxd = dv;
            end
         end
      end
      maxd = maxd * scale_sh;
      cnt = (count_sh > RULE_REGS) ? RULE_REGS : count_sh;
      best = -1;
      bestp = 0;
      for (int i = 0; i < cnt; i++) begin
         w = rule_sh[i];
         pr = w[RULE_PRI_LSB +: PRIO_W];
         if (match_sh[MATCH_HEIGHT_BIT] &&
             (h < int'($signed(w[RULE_MIN_LSB +: 16])) ||
              h > int'($signed(w[RULE_MAX_LSB +: 16]))))
            continue;
         if (match_sh[MATCH_SLOPE_BIT] &&
             !slope_pass(maxd, w[RULE_SLO_LSB +: SLOPE_W], w[RULE_SHI_LSB +: SLOPE_W]))
            continue;
         if (best < 0 || pr >= bestp) begin
            best = i;
            bestp = pr;
         end
      end
      res.layer_index = (best < 0) ? '0 : best[1:0];
      res.painted     = (best >= 0);
      res.frame_end   = (e == n * n - 1);
      return res;
   endfunction

   // advance the frame state for one accepted transaction
   function automatic void track_sample(logic mode, logic [15:0] height);
      int unsigned n, total, e;
      bit          release_one;
      n = map_side();
      total = n * n;
      e = cells_out;
      release_one = 1'b0;
      if (mode == MODE_SAMPLE && cells_in < total) begin
         cell_height[cells_in] = $signed(height);
         cells_in++;
         if (e < total && cells_in >= e + n + 2) release_one = 1'b1;
      end else if (cells_in >= total && e < total) begin
         release_one = 1'b1;
      end
      if (!release_one) return;
      expected_labels.push_back(label_cell(e, n));
      if (e + 1 >= total) begin
         cells_in = 0;
         cells_out = 0;
         cell_height.delete();
      end else begin
         cells_out = e + 1;
      end
   endfunction

   // driver: hold a stalled transaction, otherwise offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) track_sample(req_mode, req_height);
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() > 0 && (calm || $urandom_range(0, 99) >= 6)) begin
               sample_type s;
               s = pending_samples.pop_front();
               req_valid  <= 1'b1;
               req_mode   <= s.mode;
               req_height <= s.height;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare results and drive receiver back-pressure
   bit hold_ack = 1'b0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_labels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result idx=%0d painted=%0b end=%0b",
                           rsp_layer_index, rsp_painted, rsp_frame_end);
            end else begin
               result_type exp_r;
               exp_r = expected_labels.pop_front();
               if (exp_r.layer_index !== rsp_layer_index || exp_r.painted !== rsp_painted ||
                   exp_r.frame_end !== rsp_frame_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp idx=%0d painted=%0b end=%0b got idx=%0d painted=%0b end=%0b",
                              exp_r.layer_index, exp_r.painted, exp_r.frame_end,
                              rsp_layer_index, rsp_painted, rsp_frame_end);
               end
            end
         end
         if (hold_ask != hold_ack) begin
            hold_ack = hold_ask;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 6);
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx <= REG_LAYER3) begin
         rule_sh[idx] = value[RULE_W-1:0];
      end else if (idx == REG_GRID) begin
         grid_sh = value[GRID_W-1:0];
         cells_in = 0;
         cells_out = 0;
         cell_height.delete();
      end else if (idx == REG_MATCH) begin
         match_sh = value[MATCH_W-1:0];
      end else if (idx == REG_COUNT) begin
         count_sh = value[COUNT_W-1:0];
      end else begin
         scale_sh = value[SCALE_W-1:0];
      end
   endtask

   // wait for all transactions and results, then let the pipeline drain
   task automatic settle();
      while (pending_samples.size() > 0 || req_valid || expected_labels.size() > 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic push_item(logic mode, logic [15:0] height);
      sample_type s;
      s.mode = mode;
      s.height = height;
      pending_samples.push_back(s);
   endtask

   function automatic logic [RULE_W-1:0] make_rule();
      logic [RULE_W-1:0] w;
      logic [15:0]       a, b;
      w = {$urandom, $urandom};
      a = $urandom;
      b = $urandom;
      if ($urandom_range(0, 3) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
      if ($urandom_range(0, 4) == 0) begin
         a = 16'h8000;
         b = 16'h7fff;
      end
      w[RULE_MIN_LSB +: 16] = a;
      w[RULE_MAX_LSB +: 16] = b;
      if ($urandom_range(0, 3) != 0) begin
         w[RULE_SLO_LSB +: SLOPE_W] = $urandom_range(0, 60);
         w[RULE_SHI_LSB +: SLOPE_W] = $urandom_range(30, 127);
      end
      if ($urandom_range(0, 1) != 0) w[RULE_PRI_LSB +: PRIO_W] = $urandom_range(0, 2);
      return w;
   endfunction

   function automatic logic [15:0] pick_height(int style);
      case (style)
         0: return $urandom;
         1: return $urandom_range(0, 8) - 4;
         2: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
         default: return $urandom_range(0, 400) - 200;
      endcase
   endfunction

   // full map plus the flush transactions that drain it, with some noise
   task automatic stream_map(int unsigned n);
      int style;
      style = $urandom_range(0, 3);
      for (int unsigned i = 0; i < n * n; i++) begin
         if ($urandom_range(0, 29) == 0) push_item(MODE_FLUSH, $urandom);
         push_item(MODE_SAMPLE, pick_height(style));
      end
      for (int unsigned i = 0; i < n + 2; i++)
         push_item(($urandom_range(0, 4) == 0) ? MODE_SAMPLE : MODE_FLUSH, $urandom);
   endtask

   task automatic random_config();
      int unsigned g;
      for (int i = 0; i < RULE_REGS; i++) write_reg(i[CSR_IDX_W-1:0], make_rule());
      write_reg(REG_MATCH, $urandom_range(0, 3));
      write_reg(REG_COUNT, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : 4);
      case ($urandom_range(0, 5))
         0: write_reg(REG_SCALE, 0);
         1: write_reg(REG_SCALE, 16'hffff);
         2: write_reg(REG_SCALE, $urandom);
         default: write_reg(REG_SCALE, $urandom_range(16, 1024));
      endcase
      case ($urandom_range(0, 9))
         0: g = 0;
         1: g = 1;
         default: g = $urandom_range(2, 7);
      endcase
      write_reg(REG_GRID, g);
   endtask

   initial begin
      logic [RULE_W-1:0] w;
      for (int i = 0; i < RULE_REGS; i++) rule_sh[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: single cell map with reset settings but layer count 4, early flush
      write_reg(REG_COUNT, 4);
      push_item(MODE_FLUSH, 16'h0);
      push_item(MODE_SAMPLE, 16'h8000);
      push_item(MODE_FLUSH, 16'h0);
      settle();

      // directed: 3x3 map, flat slope band, steep band, tie on priority
      w = '0;
      w[RULE_MIN_LSB +: 16] = 16'h8000;
      w[RULE_MAX_LSB +: 16] = 16'h7fff;
      w[RULE_SLO_LSB +: SLOPE_W] = SLOPE_ZERO;
      w[RULE_SHI_LSB +: SLOPE_W] = SLOPE_45;
      w[RULE_PRI_LSB +: PRIO_W] = 8'd5;
      write_reg(REG_LAYER0, w);
      w[RULE_SLO_LSB +: SLOPE_W] = SLOPE_45;
      w[RULE_SHI_LSB +: SLOPE_W] = SLOPE_RIGHT;
      write_reg(REG_LAYER1, w);
      w[RULE_SLO_LSB +: SLOPE_W] = SLOPE_RIGHT;
      w[RULE_SHI_LSB +: SLOPE_W] = 7'd127;
      write_reg(REG_LAYER2, w);
      w[RULE_MIN_LSB +: 16] = 16'd0;
      w[RULE_MAX_LSB +: 16] = 16'd0;
      w[RULE_SLO_LSB +: SLOPE_W] = SLOPE_ZERO;
      w[RULE_SHI_LSB +: SLOPE_W] = 7'd89;
      w[RULE_PRI_LSB +: PRIO_W] = 8'hff;
      write_reg(REG_LAYER3, w);
      write_reg(REG_GRID, 3);
      push_item(MODE_SAMPLE, 16'h7fff);
      push_item(MODE_SAMPLE, 16'h8000);
      push_item(MODE_SAMPLE, 16'h0);
      push_item(MODE_SAMPLE, 16'h0001);
      push_item(MODE_SAMPLE, 16'h0000);
      push_item(MODE_SAMPLE, 16'h0001);
      push_item(MODE_SAMPLE, 16'h0000);
      push_item(MODE_SAMPLE, 16'hffff);
      push_item(MODE_SAMPLE, 16'h0000);
      repeat (5) push_item(MODE_FLUSH, 16'hffff);
      settle();

      // directed: sample after the full map acts as a flush
      write_reg(REG_MATCH, 2'd1);
      write_reg(REG_GRID, 2);
      for (int i = 0; i < 4; i++) push_item(MODE_SAMPLE, 16'h5555 << i);
      push_item(MODE_SAMPLE, 16'haaaa);
      repeat (3) push_item(MODE_FLUSH, 16'h0);
      settle();

      // receiver holds off while a clean map streams in
      calm = 1'b1;
      write_reg(REG_MATCH, 2'd3);
      write_reg(REG_SCALE, 16'hffff);
      write_reg(REG_GRID, 6);
      hold_ask = ~hold_ask;
      stream_map(6);
      settle();
      calm = 1'b0;

      // large maps: partial frames only, then a restart
      write_reg(REG_GRID, 1024);
      repeat (40) push_item(MODE_SAMPLE, $urandom);
      settle();
      write_reg(REG_GRID, 2047);
      repeat (40) push_item(MODE_SAMPLE, $urandom);
      settle();

      // random maps under random settings
      for (int phase = 0; phase < 21; phase++) begin
         random_config();
         calm = (phase % 9 == 4);
         for (int k = 0; k < 2; k++) stream_map(map_side());
         if ($urandom_range(0, 3) == 0) repeat (5) push_item(MODE_SAMPLE, $urandom);
         settle();
      end
      calm = 1'b0;

      if (mismatches == 0 && expected_labels.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
